@@ rtl/gctrim_pkg.sv @@
// shared types and constants for the glyph coverage bounding-box trim block
// no dependencies; imported by every module under rtl
`default_nettype none

package gctrim_pkg;

	// pixel coordinate and coverage byte width
	localparam int unsigned COORD_W = 8;
	// result field width (sizes reach 256)
	localparam int unsigned SIZE_W  = 9;
	// width that holds the largest region bound (4096)
	localparam int unsigned DIM_W   = 13;

	// stream data widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 40;

	// subpixel_mode register codes
	localparam logic MODE_GRAY = 1'b0;
	localparam logic MODE_LCD  = 1'b1;

	// one registered pixel after coverage detection
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               hit;
		logic               last;
	} pix_t;

	// one trim result
	typedef struct packed {
		logic [SIZE_W-1:0] trim_left;
		logic [SIZE_W-1:0] trim_top;
		logic [SIZE_W-1:0] new_width;
		logic [SIZE_W-1:0] new_height;
		logic              is_empty;
	} trim_res_t;

endpackage

`default_nettype wire

@@ rtl/gctrim_in.sv @@
// input stage: pixel register with coverage detection and bounds check
// depends on gctrim_pkg
`default_nettype none

module gctrim_in #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              subpixel_mode,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gctrim_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic                              s_tlast,
	output gctrim_pkg::pix_t                       pix_s1,
	output logic                                   valid_s1,
	input  wire logic                              take
);
	import gctrim_pkg::*;

	localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

	logic [COORD_W-1:0] col, row, ca, cb, cc;
	logic               cov_nz;
	logic               in_bounds;
	pix_t               pix_d;

	assign col = s_tdata[7:0];
	assign row = s_tdata[15:8];
	assign ca  = s_tdata[23:16];
	assign cb  = s_tdata[31:24];
	assign cc  = s_tdata[39:32];

	always_comb begin
		if (subpixel_mode == MODE_LCD) begin
			cov_nz = |(ca | cb | cc);
		end else begin
			cov_nz = |ca;
		end
		in_bounds = ({{(DIM_W-COORD_W){1'b0}}, col} < MaxW) &&
			({{(DIM_W-COORD_W){1'b0}}, row} < MaxH);
		pix_d.col  = col;
		pix_d.row  = row;
		pix_d.hit  = cov_nz && in_bounds;
		pix_d.last = s_tlast;
	end

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1 <= pix_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gctrim_box.sv @@
// box tracker: running min/max of hit rows and columns, result register
// depends on gctrim_pkg
`default_nettype none

module gctrim_box #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gctrim_pkg::pix_t pix_s1,
	input  wire logic             valid_s1,
	output logic                  take,
	output logic                  res_valid_q,
	input  wire logic             res_ready,
	output gctrim_pkg::trim_res_t res_q
);
	import gctrim_pkg::*;

	localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

	logic [COORD_W-1:0] first_row_q, last_row_q, first_col_q, last_col_q;
	logic               any_q;
	logic [COORD_W-1:0] fr_n, lr_n, fc_n, lc_n;
	logic               any_n;
	logic [DIM_W-1:0]   width, height;
	logic               slot_free;
	trim_res_t          res_d;

	// a non-last pixel never needs the result slot
	assign slot_free = !res_valid_q || res_ready;
	assign take      = valid_s1 && (!pix_s1.last || slot_free);

	always_comb begin
		fr_n  = first_row_q;
		lr_n  = last_row_q;
		fc_n  = first_col_q;
		lc_n  = last_col_q;
		any_n = any_q || pix_s1.hit;
		if (pix_s1.hit) begin
			if (!any_q) begin
				fr_n = pix_s1.row;
				lr_n = pix_s1.row;
				fc_n = pix_s1.col;
				lc_n = pix_s1.col;
			end else begin
				if (pix_s1.row < first_row_q) fr_n = pix_s1.row;
				if (pix_s1.row > last_row_q)  lr_n = pix_s1.row;
				if (pix_s1.col < first_col_q) fc_n = pix_s1.col;
				if (pix_s1.col > last_col_q)  lc_n = pix_s1.col;
			end
		end

		width  = {{(DIM_W-COORD_W){1'b0}}, pix_s1.col} + DIM_W'(1);
		height = {{(DIM_W-COORD_W){1'b0}}, pix_s1.row} + DIM_W'(1);
		if (width > MaxW)  width  = MaxW;
		if (height > MaxH) height = MaxH;

		if (any_n) begin
			res_d.trim_left  = {1'b0, fc_n};
			res_d.trim_top   = {1'b0, fr_n};
			res_d.new_width  = {1'b0, lc_n} - {1'b0, fc_n} + SIZE_W'(1);
			res_d.new_height = {1'b0, lr_n} - {1'b0, fr_n} + SIZE_W'(1);
			res_d.is_empty   = 1'b0;
		end else begin
			res_d.trim_left  = width[SIZE_W-1:0];
			res_d.trim_top   = height[SIZE_W-1:0];
			res_d.new_width  = '0;
			res_d.new_height = '0;
			res_d.is_empty   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q <= '1;
			last_row_q  <= '0;
			first_col_q <= '1;
			last_col_q  <= '0;
			any_q       <= 1'b0;
		end else if (take) begin
			if (pix_s1.last) begin
				first_row_q <= '1;
				last_row_q  <= '0;
				first_col_q <= '1;
				last_col_q  <= '0;
				any_q       <= 1'b0;
			end else begin
				first_row_q <= fr_n;
				last_row_q  <= lr_n;
				first_col_q <= fc_n;
				last_col_q  <= lc_n;
				any_q       <= any_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && pix_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pix_s1.last) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/glyph_coverage_bbox_trim_top.sv @@
// top level of the glyph coverage bounding-box trim block
// depends on gctrim_pkg, gctrim_in and gctrim_box
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata col,row,cover_a,b,c; s_tlast end of region
// m_*       out  m_tvalid/m_tready   m_tdata trims and sizes; m_tuser is_empty
// cfg_*     in   cfg_valid/cfg_ready cfg_data subpixel_mode
//
// one pixel request per clock sustained while no waiting result holds back a last pixel;
// a pixel passes an input register and reaches the box tracker the next cycle, and
// the tracker loads the result register when it takes the last pixel
// arst_n clears the box state, the mode register and both valid flags
// a stalled result only holds back a following last pixel: ordinary pixels
// keep flowing into the tracker while the result waits in its register
`default_nettype none

module glyph_coverage_bbox_trim_top #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// pixel stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [7:0] col, [15:8] row, [23:16] cover_a, [31:24] cover_b, [39:32] cover_c
	input  wire logic [gctrim_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic                               s_tlast,
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [8:0] trim_left, [17:9] trim_top, [26:18] new_width,
	// [35:27] new_height, [39:36] zero
	output logic [gctrim_pkg::OUT_DATA_W-1:0]       m_tdata,
	// [0] is_empty
	output logic                                    m_tuser,
	// mode register write
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic                               cfg_data
);
	import gctrim_pkg::*;

	logic      subpixel_mode_q;
	pix_t      pix_s1;
	logic      valid_s1;
	logic      take;
	trim_res_t res_q;

	// the mode register is always writable; writes must arrive only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subpixel_mode_q <= MODE_GRAY;
		end else if (cfg_valid && cfg_ready) begin
			subpixel_mode_q <= cfg_data;
		end
	end

	// coverage test and bounds check happen before the input register
	gctrim_in #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.subpixel_mode (subpixel_mode_q),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.pix_s1        (pix_s1),
		.valid_s1      (valid_s1),
		.take          (take)
	);

	// running box and result formation
	gctrim_box #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_box (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_s1      (pix_s1),
		.valid_s1    (valid_s1),
		.take        (take),
		.res_valid_q (m_tvalid),
		.res_ready   (m_tready),
		.res_q       (res_q)
	);

	// pack the result, padding the top nibble with zeros
	assign m_tdata = {4'b0000, res_q.new_height, res_q.new_width,
		res_q.trim_top, res_q.trim_left};
	assign m_tuser = res_q.is_empty;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for glyph_coverage_bbox_trim_top: pixel requests in, trim results out
// depends on gctrim_pkg and the top level under rtl; keeps its own bounding-box tracker

module testbench;

	// region bounds, matched to the parameters of the instance below
	localparam int MAX_W = 256;
	localparam int MAX_H = 256;
	// leave room before a mode write
	localparam int DRAIN_CYCLES = 8;
	// hard stop, far beyond the slowest correct run
	localparam int CYCLE_LIMIT = 500000;
	localparam int N_PLAN = 18;

	// one pixel request, packed so that col lands in the lowest bits of s_tdata
	typedef struct packed {
		logic [7:0] cover_c;
		logic [7:0] cover_b;
		logic [7:0] cover_a;
		logic [7:0] row;
		logic [7:0] col;
	} pixel_req_t;

	// one row of the directed plan: optional mode write, the pixel, an optional typed result
	typedef struct packed {
		logic                  set_mode;
		logic                  mode_val;
		pixel_req_t            px;
		logic                  last;
		logic                  typed;
		gctrim_pkg::trim_res_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// tracker state of the region in flight
	logic [7:0] box_top;
	logic [7:0] box_bot;
	logic [7:0] box_left;
	logic [7:0] box_right;
	logic       box_any;
	logic       lcd_mode;

	// results still owed by the block, oldest first
	gctrim_pkg::trim_res_t trims_due[$];

	int  fails = 0;
	int  cycles = 0;
	int  pix_sent = 0;
	bit  src_quiet = 1'b0;
	bit  ended_on_last;
	int  rdy_left = 0;

	glyph_coverage_bbox_trim_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [7:0] col, [15:8] row, [23:16] cover_a, [31:24] cover_b, [39:32] cover_c
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [8:0] trim_left, [17:9] trim_top, [26:18] new_width, [35:27] new_height
		.m_tuser(m_tuser),     // [0] is_empty
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// directed plan: typed results only where the answer is plain at a glance
	localparam plan_row_t PLAN [N_PLAN] = '{
		// after reset, grayscale: empty one-pixel region reports its full size as trim
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h00, 8'd0, 8'd0}, 1'b1, 1'b1, {9'd1, 9'd1, 9'd0, 9'd0, 1'b1}},
		// single covered pixel
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'hff, 8'd0, 8'd0}, 1'b1, 1'b1, {9'd0, 9'd0, 9'd1, 9'd1, 1'b0}},
		// largest empty region, second and third bytes ignored in grayscale
		'{1'b0, 1'b0, {8'hff, 8'hff, 8'h00, 8'd255, 8'd255}, 1'b1, 1'b1,
			{9'd256, 9'd256, 9'd0, 9'd0, 1'b1}},
		// only the bottom-right pixel covered, so its own coverage must count
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h01, 8'd255, 8'd255}, 1'b1, 1'b1,
			{9'd255, 9'd255, 9'd1, 9'd1, 1'b0}},
		// small region with scattered hits, checked against the tracker
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h80, 8'd0, 8'd4}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'haa, 8'h55, 8'h00, 8'd2, 8'd1}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h01, 8'd1, 8'd6}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h00, 8'd3, 8'd0}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h7f, 8'd5, 8'd2}, 1'b1, 1'b0, '0},
		// out of order: the hit lies beyond the last pixel of the region
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h20, 8'd7, 8'd9}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h00, 8'd1, 8'd3}, 1'b1, 1'b0, '0},
		// lcd mode: any of the three bytes makes a hit
		'{1'b1, gctrim_pkg::MODE_LCD, {8'h00, 8'h40, 8'h00, 8'd1, 8'd1}, 1'b1, 1'b1,
			{9'd1, 9'd1, 9'd1, 9'd1, 1'b0}},
		'{1'b0, 1'b0, {8'h80, 8'h00, 8'h00, 8'd0, 8'd7}, 1'b1, 1'b1, {9'd7, 9'd0, 9'd1, 9'd1, 1'b0}},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h00, 8'd0, 8'd0}, 1'b1, 1'b1, {9'd1, 9'd1, 9'd0, 9'd0, 1'b1}},
		// opposite corners covered: box spans the whole region
		'{1'b0, 1'b0, {8'hff, 8'h00, 8'h00, 8'd0, 8'd255}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'hff, 8'hff, 8'hff, 8'd255, 8'd0}, 1'b0, 1'b0, '0},
		'{1'b0, 1'b0, {8'h00, 8'h00, 8'h00, 8'd255, 8'd255}, 1'b1, 1'b1,
			{9'd0, 9'd0, 9'd256, 9'd256, 1'b0}},
		'{1'b0, 1'b0, {8'h00, 8'h01, 8'h00, 8'd64, 8'd128}, 1'b1, 1'b1,
			{9'd128, 9'd64, 9'd1, 9'd1, 1'b0}}
	};

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: stretches of ready, short stalls and the odd long one
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					m_tready <= 1'b1;
					rdy_left = $urandom_range(1, 30);
				end
				4, 5, 6, 7: begin
					m_tready <= 1'b0;
					rdy_left = $urandom_range(1, 3);
				end
				8: begin
					m_tready <= 1'b0;
					rdy_left = $urandom_range(8, 40);
				end
				default: begin
					m_tready <= 1'b1;
					rdy_left = $urandom_range(50, 120);
				end
			endcase
		end else begin
			rdy_left = rdy_left - 1;
		end
	end

	function automatic void cmp_field(string name, logic [8:0] want, logic [8:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endfunction

	// every accepted result is matched against the oldest owed one
	always @(posedge clk) begin : rx_check
		gctrim_pkg::trim_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (trims_due.size() == 0) begin
				$error("result with none outstanding: tdata %h tuser %b", m_tdata, m_tuser);
				fails++;
			end else begin
				want = trims_due.pop_front();
				cmp_field("trim_left", want.trim_left, m_tdata[8:0]);
				cmp_field("trim_top", want.trim_top, m_tdata[17:9]);
				cmp_field("new_width", want.new_width, m_tdata[26:18]);
				cmp_field("new_height", want.new_height, m_tdata[35:27]);
				cmp_field("is_empty", {8'd0, want.is_empty}, {8'd0, m_tuser});
			end
		end
	end

	function automatic void box_clear();
		box_top = 8'hff;
		box_bot = 8'h00;
		box_left = 8'hff;
		box_right = 8'h00;
		box_any = 1'b0;
	endfunction

	// tracker: widen the box on a hit, on the last pixel owe a result and start over
	function automatic void box_accept(pixel_req_t px, logic last, logic typed,
			gctrim_pkg::trim_res_t want);
		logic [7:0]            cov;
		logic [8:0]            reg_w;
		logic [8:0]            reg_h;
		gctrim_pkg::trim_res_t res;
		cov = lcd_mode ? (px.cover_a | px.cover_b | px.cover_c) : px.cover_a;
		if (cov != 8'd0 && int'(px.col) < MAX_W && int'(px.row) < MAX_H) begin
			if (!box_any) begin
				box_top = px.row;
				box_bot = px.row;
				box_left = px.col;
				box_right = px.col;
			end else begin
				if (px.row < box_top) box_top = px.row;
				if (px.row > box_bot) box_bot = px.row;
				if (px.col < box_left) box_left = px.col;
				if (px.col > box_right) box_right = px.col;
			end
			box_any = 1'b1;
		end
		if (last) begin
			// region size comes from the last pixel, saturated at the bounds
			reg_w = {1'b0, px.col} + 9'd1;
			reg_h = {1'b0, px.row} + 9'd1;
			if (int'(reg_w) > MAX_W) reg_w = MAX_W[8:0];
			if (int'(reg_h) > MAX_H) reg_h = MAX_H[8:0];
			if (box_any) begin
				res.trim_left = {1'b0, box_left};
				res.trim_top = {1'b0, box_top};
				res.new_width = {1'b0, box_right} - {1'b0, box_left} + 9'd1;
				res.new_height = {1'b0, box_bot} - {1'b0, box_top} + 9'd1;
				res.is_empty = 1'b0;
			end else begin
				// nothing covered: trims equal the full size
				res.trim_left = reg_w;
				res.trim_top = reg_h;
				res.new_width = 9'd0;
				res.new_height = 9'd0;
				res.is_empty = 1'b1;
			end
			trims_due.push_back(typed ? want : res);
			box_clear();
		end
	endfunction

	// sender gap: mostly none, some short, a few long; none at all in quiet stretches
	function automatic int src_gap();
		int r;
		r = $urandom_range(0, 9);
		if (src_quiet || r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(5, 24);
	endfunction

	// one pixel request; valid stays high into the next request when no gap follows
	task automatic send_pixel(input pixel_req_t px, input logic last, input logic typed = 1'b0,
			input gctrim_pkg::trim_res_t want = '0);
		int gap;
		gap = src_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		box_accept(px, last, typed, want);
		pix_sent++;
		ended_on_last = last;
	endtask

	// mode write only once the block has nothing left in flight
	task automatic write_mode(input logic mode);
		s_tvalid <= 1'b0;
		while (trims_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lcd_mode = (mode == gctrim_pkg::MODE_LCD);
	endtask

	// coverage byte; dens 0 gives zero always, 8 gives nonzero always
	function automatic logic [7:0] cover_byte(int dens);
		if ($urandom_range(0, 7) >= dens) return 8'h00;
		case ($urandom_range(0, 3))
			0: return 8'h01;
			1: return 8'h80;
			2: return 8'hff;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic pixel_req_t make_pixel(int col, int row, int dens);
		pixel_req_t px;
		px.col = 8'(col);
		px.row = 8'(row);
		px.cover_a = cover_byte(dens);
		px.cover_b = cover_byte(dens);
		px.cover_c = cover_byte(dens);
		return px;
	endfunction

	// random phase: mostly well-formed regions, some sparse large ones, some noise
	task automatic run_phase(input logic mode, input int n_pix);
		int goal;
		int kind;
		int dens;
		int reg_w;
		int reg_h;
		int n_hits;
		write_mode(mode);
		goal = pix_sent + n_pix;
		while (pix_sent < goal) begin
			kind = $urandom_range(0, 9);
			dens = $urandom_range(0, 4);
			src_quiet = ($urandom_range(0, 4) == 0);
			if (kind < 6) begin
				// raster region, small, last flag on its bottom-right pixel
				reg_w = $urandom_range(1, 8);
				reg_h = $urandom_range(1, 6);
				for (int r = 0; r < reg_h; r++)
					for (int c = 0; c < reg_w; c++)
						send_pixel(make_pixel(c, r, dens), (r == reg_h - 1) && (c == reg_w - 1));
			end else if (kind < 8) begin
				// sparse region: a few pixels anywhere inside, then the closing corner
				reg_w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
				reg_h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
				n_hits = $urandom_range(0, 6);
				repeat (n_hits)
					send_pixel(make_pixel($urandom_range(0, reg_w - 1), $urandom_range(0, reg_h - 1),
						dens + 2), 1'b0);
				send_pixel(make_pixel(reg_w - 1, reg_h - 1, dens), 1'b1);
			end else begin
				// noise: anything at all, last now and then
				repeat ($urandom_range(1, 10))
					send_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 8)), ($urandom_range(0, 5) == 0));
			end
		end
		// close an open region so the next mode write finds the block idle
		if (!ended_on_last)
			send_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 255), 4), 1'b1);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		lcd_mode = 1'b0;
		box_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan, starting from the reset mode
		for (int i = 0; i < N_PLAN; i++) begin
			if (PLAN[i].set_mode)
				write_mode(PLAN[i].mode_val);
			send_pixel(PLAN[i].px, PLAN[i].last, PLAN[i].typed, PLAN[i].want);
		end

		run_phase(gctrim_pkg::MODE_GRAY, 240);
		run_phase(gctrim_pkg::MODE_LCD, 240);
		run_phase(gctrim_pkg::MODE_GRAY, 230);
		run_phase(gctrim_pkg::MODE_LCD, 240);

		// drain: wait out every owed result, then a further wait for strays
		s_tvalid <= 1'b0;
		while (trims_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
